[hw/rtl/brfmt_pkg.sv]
// Package for the box region first-match table.
// Holds the table sizing, field widths, command and status codes, FSM states
// and the control/status structs between the controller and the datapath.
`default_nettype none

package brfmt_pkg;

	// table sizing and fixed-point format
	localparam int MAX_ENTRIES = 64;
	localparam int FRAC_BITS   = 4;
	localparam int IDX_W       = 6;                    // entry index width
	localparam int CNT_W       = 7;                    // entry count width
	localparam int CRD_W       = 16;                   // integer coordinate width
	localparam int HALF_W      = 8;                    // half size register width
	localparam int QRY_W       = 20;                   // query point width
	localparam int SUM_W       = CRD_W + 2;            // centre +/- half, exact
	localparam int BND_W       = SUM_W + FRAC_BITS;    // scaled bound
	localparam int ENT_W       = 4 * CRD_W;            // one stored entry

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

	// configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_HALF_WIDTH  = 1'b0;
	localparam logic REG_HALF_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		CMD_APPEND = 2'd0,
		CMD_CLEAR  = 2'd1,
		CMD_LOOKUP = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_FULL      = 2'd1,
		STS_BAD_INDEX = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_APPEND,
		ST_CLEAR,
		ST_RD_REQ,
		ST_RD_DATA,
		ST_SCAN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    load;        // capture the command payload
		logic    append;      // write the captured entry if room
		logic    clear;       // empty the table
		logic    rd_entry;    // read the entry at the captured index
		logic    scan_run;    // advance the lookup scan
		logic    emit;        // load the result registers
		logic    emit_entry;  // result carries the compared entry
		status_t emit_status;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;       // table holds MAX_ENTRIES entries
		logic idx_ok;     // captured read index is below the count
		logic hit;        // entry in flight contains the query point
		logic scan_done;  // every entry issued and compared
	} dp_stat_t;

endpackage

`default_nettype wire

[hw/rtl/brfmt_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package dependency.
`default_nettype none

module brfmt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/brfmt_ctrl.sv]
// Controller FSM of the box region first-match table.
// Depends on brfmt_pkg; drives brfmt_dp through ctrl_cmd_t, watches dp_stat_t.
`default_nettype none

module brfmt_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [1:0]           command,
	input  wire brfmt_pkg::dp_stat_t  stat,
	output brfmt_pkg::ctrl_cmd_t      cmd,
	output logic                      busy
);

	brfmt_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= brfmt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_d         = state_q;
		cmd             = '0;
		cmd.emit_status = brfmt_pkg::STS_OK;
		busy            = (state_q != brfmt_pkg::ST_IDLE);
		case (state_q)
			brfmt_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					case (brfmt_pkg::cmd_t'(command))
						brfmt_pkg::CMD_APPEND: state_d = brfmt_pkg::ST_APPEND;
						brfmt_pkg::CMD_CLEAR:  state_d = brfmt_pkg::ST_CLEAR;
						brfmt_pkg::CMD_LOOKUP: state_d = brfmt_pkg::ST_SCAN;
						brfmt_pkg::CMD_READ:   state_d = brfmt_pkg::ST_RD_REQ;
						default:               state_d = brfmt_pkg::ST_IDLE;
					endcase
				end
			end
			brfmt_pkg::ST_APPEND: begin
				cmd.append      = 1'b1;
				cmd.emit        = 1'b1;
				cmd.emit_status = stat.full ? brfmt_pkg::STS_FULL : brfmt_pkg::STS_OK;
				state_d         = brfmt_pkg::ST_IDLE;
			end
			brfmt_pkg::ST_CLEAR: begin
				cmd.clear = 1'b1;
				cmd.emit  = 1'b1;
				state_d   = brfmt_pkg::ST_IDLE;
			end
			brfmt_pkg::ST_RD_REQ: begin
				// issue the read, or report the bad index at once
				if (stat.idx_ok) begin
					cmd.rd_entry = 1'b1;
					state_d      = brfmt_pkg::ST_RD_DATA;
				end else begin
					cmd.emit        = 1'b1;
					cmd.emit_status = brfmt_pkg::STS_BAD_INDEX;
					state_d         = brfmt_pkg::ST_IDLE;
				end
			end
			brfmt_pkg::ST_RD_DATA: begin
				cmd.emit       = 1'b1;
				cmd.emit_entry = 1'b1;
				state_d        = brfmt_pkg::ST_IDLE;
			end
			brfmt_pkg::ST_SCAN: begin
				// stop at the first hit, or once every entry has missed
				cmd.scan_run = 1'b1;
				if (stat.hit) begin
					cmd.emit       = 1'b1;
					cmd.emit_entry = 1'b1;
					state_d        = brfmt_pkg::ST_IDLE;
				end else if (stat.scan_done) begin
					cmd.emit = 1'b1;
					state_d  = brfmt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = brfmt_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/brfmt_dp.sv]
// Datapath of the box region first-match table: payload capture, entry RAM,
// count, scan index, box containment test and result registers.
// Depends on brfmt_pkg and brfmt_ram.
`default_nettype none

module brfmt_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire brfmt_pkg::ctrl_cmd_t                cmd,
	output brfmt_pkg::dp_stat_t                      stat,
	input  wire logic [brfmt_pkg::HALF_W-1:0]        half_width,
	input  wire logic [brfmt_pkg::HALF_W-1:0]        half_height,
	input  wire logic signed [brfmt_pkg::QRY_W-1:0]  query_x,
	input  wire logic signed [brfmt_pkg::QRY_W-1:0]  query_y,
	input  wire logic signed [brfmt_pkg::CRD_W-1:0]  centre_x,
	input  wire logic signed [brfmt_pkg::CRD_W-1:0]  centre_y,
	input  wire logic signed [brfmt_pkg::CRD_W-1:0]  target_x,
	input  wire logic signed [brfmt_pkg::CRD_W-1:0]  target_y,
	input  wire logic [brfmt_pkg::IDX_W-1:0]         entry_index,
	output logic                                     done,
	output logic                                     found,
	output logic [brfmt_pkg::IDX_W-1:0]              match_index,
	output logic signed [brfmt_pkg::CRD_W-1:0]       box_x,
	output logic signed [brfmt_pkg::CRD_W-1:0]       box_y,
	output logic signed [brfmt_pkg::CRD_W-1:0]       dest_x,
	output logic signed [brfmt_pkg::CRD_W-1:0]       dest_y,
	output logic [1:0]                               status,
	output logic [brfmt_pkg::CNT_W-1:0]              entry_count
);

	localparam int IW = brfmt_pkg::IDX_W;
	localparam int CW = brfmt_pkg::CNT_W;
	localparam int DW = brfmt_pkg::CRD_W;

	// captured payload
	logic signed [brfmt_pkg::QRY_W-1:0] qx_q, qy_q;
	logic [brfmt_pkg::ENT_W-1:0]        new_ent_q;
	logic [IW-1:0]                      rd_idx_q;

	// table state and scan control
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] issue_q;
	logic          pend_q;
	logic [IW-1:0] cmp_idx_q;

	// RAM signals
	logic                        ram_we, ram_re;
	logic [IW-1:0]               ram_raddr;
	logic [brfmt_pkg::ENT_W-1:0] ram_rdata;
	logic signed [DW-1:0]        ent_cx, ent_cy, ent_tx, ent_ty;
	logic                        scan_issue, match;

	// inclusive test of q against (c +/- half) scaled to fixed point
	function automatic logic in_box(
		input logic signed [brfmt_pkg::QRY_W-1:0]  q,
		input logic signed [DW-1:0]                c,
		input logic [brfmt_pkg::HALF_W-1:0]        half
	);
		logic signed [brfmt_pkg::SUM_W-1:0] c_ext, h_ext, lo, hi;
		logic signed [brfmt_pkg::BND_W-1:0] q_ext, lo_s, hi_s;
		c_ext = {{(brfmt_pkg::SUM_W-DW){c[DW-1]}}, c};
		h_ext = {{(brfmt_pkg::SUM_W-brfmt_pkg::HALF_W){1'b0}}, half};
		lo    = c_ext - h_ext;
		hi    = c_ext + h_ext;
		lo_s  = {lo, {brfmt_pkg::FRAC_BITS{1'b0}}};
		hi_s  = {hi, {brfmt_pkg::FRAC_BITS{1'b0}}};
		q_ext = {{(brfmt_pkg::BND_W-brfmt_pkg::QRY_W){q[brfmt_pkg::QRY_W-1]}}, q};
		return (q_ext >= lo_s) && (q_ext <= hi_s);
	endfunction

	// capture the payload of an accepted command
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			qx_q      <= query_x;
			qy_q      <= query_y;
			new_ent_q <= {centre_x, centre_y, target_x, target_y};
			rd_idx_q  <= entry_index;
		end
	end

	assign ent_cx = ram_rdata[4*DW-1:3*DW];
	assign ent_cy = ram_rdata[3*DW-1:2*DW];
	assign ent_tx = ram_rdata[2*DW-1:DW];
	assign ent_ty = ram_rdata[DW-1:0];

	// status towards the controller
	assign stat.full      = (count_q == brfmt_pkg::MAX_CNT);
	assign stat.idx_ok    = ({1'b0, rd_idx_q} < count_q);
	assign match          = in_box(qx_q, ent_cx, half_width) &&
	                        in_box(qy_q, ent_cy, half_height);
	assign stat.hit       = pend_q && match;
	assign stat.scan_done = !pend_q && (issue_q >= count_q);

	// RAM port control
	assign scan_issue = cmd.scan_run && (issue_q < count_q);
	assign ram_we     = cmd.append && !stat.full;
	assign ram_re     = scan_issue || cmd.rd_entry;
	assign ram_raddr  = cmd.rd_entry ? rd_idx_q : issue_q[IW-1:0];

	brfmt_ram #(
		.WIDTH (brfmt_pkg::ENT_W),
		.DEPTH (brfmt_pkg::MAX_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[IW-1:0]),
		.wdata (new_ent_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// count after this command
	always_comb begin
		count_d = count_q;
		if (cmd.clear) begin
			count_d = '0;
		end else if (ram_we) begin
			count_d = count_q + CW'(1);
		end
	end

	// hold the count, scan index and in-flight flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			issue_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			if (cmd.load) begin
				issue_q <= '0;
				pend_q  <= 1'b0;
			end else if (cmd.scan_run) begin
				pend_q <= scan_issue;
				if (scan_issue) begin
					issue_q <= issue_q + CW'(1);
				end
			end
		end
	end

	// index of the entry whose data arrives next cycle
	always_ff @(posedge clk) begin
		if (ram_re) begin
			cmp_idx_q <= ram_raddr;
		end
	end

	// result beat strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.emit;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			found       <= cmd.emit_entry;
			match_index <= cmd.emit_entry ? cmp_idx_q : '0;
			box_x       <= cmd.emit_entry ? ent_cx : '0;
			box_y       <= cmd.emit_entry ? ent_cy : '0;
			dest_x      <= cmd.emit_entry ? ent_tx : '0;
			dest_y      <= cmd.emit_entry ? ent_ty : '0;
			status      <= cmd.emit_status;
			entry_count <= count_d;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/box_region_first_match_table.sv]
// Top level of the box region first-match table.
// Depends on brfmt_pkg, brfmt_ctrl, brfmt_dp (which holds brfmt_ram).
//
// Usage:
//  - Command channel: raise start with command and its payload; the command
//    is taken at a rising edge with start high and busy low.
//  - Result channel: done is high for exactly one cycle with the result beat
//    on found, match_index, box_x/y, dest_x/y, status and entry_count. The
//    receiver must take the beat in that cycle; it cannot stall the block.
//  - Config: APB registers half_width at 0x0 and half_height at 0x4, pready
//    tied high. Write only while no command is in progress.
// Accept to done (done registered from the emitting state): append and
// clear emit from one state; read emits from a data state after a request
// state, or at once on a bad index; lookup emits on the first hit, or once
// all stored entries missed (at once if empty). The entry RAM delivers one
// entry per cycle, tested against the query in the cycle it arrives.
// One command is processed at a time; busy falls as done rises, so the next
// command may be accepted in the cycle its predecessor's result is shown.
// Reset empties the table (entry count zero) and sets both half sizes to 8;
// the RAM itself is not cleared and needs no clearing pass.
`default_nettype none

module box_region_first_match_table (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// command channel
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [1:0]                          command,
	input  wire logic signed [brfmt_pkg::QRY_W-1:0]  query_x,
	input  wire logic signed [brfmt_pkg::QRY_W-1:0]  query_y,
	input  wire logic signed [brfmt_pkg::CRD_W-1:0]  centre_x,
	input  wire logic signed [brfmt_pkg::CRD_W-1:0]  centre_y,
	input  wire logic signed [brfmt_pkg::CRD_W-1:0]  target_x,
	input  wire logic signed [brfmt_pkg::CRD_W-1:0]  target_y,
	input  wire logic [brfmt_pkg::IDX_W-1:0]         entry_index,
	// result channel
	output logic                                     done,
	output logic                                     found,
	output logic [brfmt_pkg::IDX_W-1:0]              match_index,
	output logic signed [brfmt_pkg::CRD_W-1:0]       box_x,
	output logic signed [brfmt_pkg::CRD_W-1:0]       box_y,
	output logic signed [brfmt_pkg::CRD_W-1:0]       dest_x,
	output logic signed [brfmt_pkg::CRD_W-1:0]       dest_y,
	output logic [1:0]                               status,
	output logic [brfmt_pkg::CNT_W-1:0]              entry_count,
	// configuration port
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [brfmt_pkg::APB_AW-1:0]        paddr,
	input  wire logic [brfmt_pkg::APB_DW-1:0]        pwdata,
	output logic [brfmt_pkg::APB_DW-1:0]             prdata,
	output logic                                     pready
);

	logic [brfmt_pkg::HALF_W-1:0] half_width_q, half_height_q;
	logic                         cfg_wr;
	brfmt_pkg::ctrl_cmd_t         cmd;
	brfmt_pkg::dp_stat_t          stat;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q  <= brfmt_pkg::HALF_W'(8);
			half_height_q <= brfmt_pkg::HALF_W'(8);
		end else if (cfg_wr) begin
			if (paddr[2] == brfmt_pkg::REG_HALF_WIDTH) begin
				half_width_q <= pwdata[brfmt_pkg::HALF_W-1:0];
			end else begin
				half_height_q <= pwdata[brfmt_pkg::HALF_W-1:0];
			end
		end
	end

	// register read-back
	assign prdata = (paddr[2] == brfmt_pkg::REG_HALF_HEIGHT) ?
		{{(brfmt_pkg::APB_DW-brfmt_pkg::HALF_W){1'b0}}, half_height_q} :
		{{(brfmt_pkg::APB_DW-brfmt_pkg::HALF_W){1'b0}}, half_width_q};

	brfmt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.stat    (stat),
		.cmd     (cmd),
		.busy    (busy)
	);

	brfmt_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.half_width  (half_width_q),
		.half_height (half_height_q),
		.query_x     (query_x),
		.query_y     (query_y),
		.centre_x    (centre_x),
		.centre_y    (centre_y),
		.target_x    (target_x),
		.target_y    (target_y),
		.entry_index (entry_index),
		.done        (done),
		.found       (found),
		.match_index (match_index),
		.box_x       (box_x),
		.box_y       (box_y),
		.dest_x      (dest_x),
		.dest_y      (dest_y),
		.status      (status),
		.entry_count (entry_count)
	);

`ifndef ASSERT_OFF
	// an accepted command makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not raise busy");

	// a result beat always coincides with the return to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while still busy");

	// a full-table report only when the table really is full
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == brfmt_pkg::STS_FULL) |-> (entry_count == brfmt_pkg::MAX_CNT))
		else $error("table full reported below capacity");

	// a returned entry lies inside the occupied part of the table
	a_found_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && found |-> ({1'b0, match_index} < entry_count))
		else $error("returned entry index beyond entry count");
`endif

endmodule

`default_nettype wire
